FILE: src/u8u16_pkg.sv
`default_nettype none

package u8u16_pkg;

  // Result buffering
  localparam int MaxUnits   = 4;
  localparam int NumW       = $clog2(MaxUnits + 1);
  localparam int QueueDepth = 8;
  localparam int QueueAw    = $clog2(QueueDepth);
  localparam int CntW       = QueueAw + 1;

  // Character constants
  localparam logic [15:0] ReplChar     = 16'hFFFD;
  localparam logic [15:0] HighSurrBase = 16'hD800;
  localparam logic [15:0] LowSurrBase  = 16'hDC00;
  localparam logic [20:0] SuppFirst    = 21'h10000;
  localparam logic [20:0] SuppLast     = 21'h10FFFF;

  // Lead byte classes
  localparam logic [7:0] ContMask  = 8'hC0;
  localparam logic [7:0] ContTag   = 8'h80;
  localparam logic [7:0] Lead2Mask = 8'hE0;
  localparam logic [7:0] Lead2Tag  = 8'hC0;
  localparam logic [7:0] Lead3Mask = 8'hF0;
  localparam logic [7:0] Lead3Tag  = 8'hE0;
  localparam logic [7:0] Lead4Mask = 8'hF8;
  localparam logic [7:0] Lead4Tag  = 8'hF0;
  localparam logic [7:0] Pay2Mask  = 8'h1F;
  localparam logic [7:0] Pay3Mask  = 8'h0F;
  localparam logic [7:0] Pay4Mask  = 8'h07;

  // Sequence lengths
  localparam logic [2:0] LenNone = 3'd0;
  localparam logic [2:0] Len2    = 3'd2;
  localparam logic [2:0] Len3    = 3'd3;
  localparam logic [2:0] Len4    = 3'd4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_buffer;
  } byte_item_t;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        is_replacement;
    logic        last_of_run;
    logic        end_of_text;
  } unit_item_t;

  typedef unit_item_t [MaxUnits-1:0] unit_set_t;

  // Units produced by one byte, handed from decoder to result queue
  typedef struct packed {
    logic [NumW-1:0] num;
    unit_set_t       units;
  } unit_batch_t;

endpackage

`default_nettype wire

FILE: src/u8u16_dec.sv
`default_nettype none

module u8u16_dec
  import u8u16_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        fire,
  input  wire byte_item_t  item,
  output unit_batch_t      batch
);

  logic [2:0]  exp_len, exp_len_next;
  logic [1:0]  collected, collected_next;
  logic [20:0] partial, partial_next;

  logic [7:0]      b;
  logic            eob;
  logic            pending;
  logic            is_cont;
  logic [20:0]     acc;
  logic [1:0]      coll_inc;
  logic [20:0]     supp_off;
  logic            in_supp;
  logic [NumW-1:0] flush_cnt;
  logic [NumW-1:0] num;
  logic [NumW-1:0] last_idx;
  unit_item_t      lead_unit;
  unit_item_t      repl_unit;
  unit_set_t       units;

  assign b         = item.data_byte;
  assign eob       = item.end_of_buffer;
  assign pending   = (exp_len != LenNone);
  assign is_cont   = ((b & ContMask) == ContTag);
  assign acc       = {partial[14:0], b[5:0]};
  assign coll_inc  = collected + 2'd1;
  assign supp_off  = acc - SuppFirst;
  assign in_supp   = (acc >= SuppFirst) && (acc <= SuppLast);
  assign repl_unit = '{code_unit: ReplChar, is_replacement: 1'b1,
                       last_of_run: 1'b0, end_of_text: 1'b0};

  // Decode one byte against the pending sequence
  always_comb begin
    exp_len_next   = exp_len;
    collected_next = collected;
    partial_next   = partial;
    units          = {MaxUnits{repl_unit}};
    num            = '0;
    flush_cnt      = '0;
    lead_unit      = repl_unit;
    last_idx       = '0;
    if (pending && is_cont) begin
      partial_next   = acc;
      collected_next = coll_inc;
      if (({1'b0, coll_inc} + 3'd1) >= exp_len) begin
        exp_len_next   = LenNone;
        collected_next = '0;
        partial_next   = '0;
        if (exp_len == Len4) begin
          if (in_supp) begin
            units[0].code_unit      = HighSurrBase | {6'd0, supp_off[19:10]};
            units[0].is_replacement = 1'b0;
            units[1].code_unit      = LowSurrBase | {6'd0, supp_off[9:0]};
            units[1].is_replacement = 1'b0;
            num = NumW'(2);
          end else begin
            num = NumW'(1);
          end
        end else begin
          units[0].code_unit      = acc[15:0];
          units[0].is_replacement = 1'b0;
          num = NumW'(1);
        end
      end else if (eob) begin
        // buffer ends mid-sequence: one replacement per byte seen
        exp_len_next   = LenNone;
        collected_next = '0;
        partial_next   = '0;
        num = NumW'(coll_inc) + NumW'(1);
      end
    end else begin
      // flush any broken sequence, then scan this byte as a lead
      if (pending) begin
        flush_cnt = NumW'(collected) + NumW'(1);
      end
      exp_len_next   = LenNone;
      collected_next = '0;
      partial_next   = '0;
      priority if (!b[7]) begin
        lead_unit.code_unit      = {8'd0, b};
        lead_unit.is_replacement = 1'b0;
      end else if ((b & Lead2Mask) == Lead2Tag) begin
        exp_len_next = Len2;
        partial_next = {13'd0, b & Pay2Mask};
      end else if ((b & Lead3Mask) == Lead3Tag) begin
        exp_len_next = Len3;
        partial_next = {13'd0, b & Pay3Mask};
      end else if ((b & Lead4Mask) == Lead4Tag) begin
        exp_len_next = Len4;
        partial_next = {13'd0, b & Pay4Mask};
      end else begin
        lead_unit = repl_unit;
      end
      if (exp_len_next != LenNone && eob) begin
        exp_len_next = LenNone;
        partial_next = '0;
      end
      if (exp_len_next == LenNone) begin
        units[flush_cnt[1:0]] = lead_unit;
        num = flush_cnt + NumW'(1);
      end else begin
        num = flush_cnt;
      end
    end
    // tag the final unit of this byte
    if (num != '0) begin
      last_idx = num - NumW'(1);
      units[last_idx[1:0]].last_of_run = 1'b1;
      units[last_idx[1:0]].end_of_text = eob;
    end
  end

  assign batch.num   = num;
  assign batch.units = units;

  // Sequence state
  always_ff @(posedge clk) begin
    if (rst) begin
      exp_len   <= LenNone;
      collected <= '0;
      partial   <= '0;
    end else if (fire) begin
      exp_len   <= exp_len_next;
      collected <= collected_next;
      partial   <= partial_next;
    end
  end

  a_len_legal: assert property (@(posedge clk) disable iff (rst)
    exp_len == LenNone || exp_len == Len2 || exp_len == Len3 || exp_len == Len4)
    else $error("pending length out of range");

  a_coll_short: assert property (@(posedge clk) disable iff (rst)
    pending |-> ({1'b0, collected} + 3'd1) < exp_len)
    else $error("pending sequence already complete");

  a_num_bound: assert property (@(posedge clk) disable iff (rst)
    fire |-> batch.num <= NumW'(MaxUnits))
    else $error("too many units for one byte");

endmodule

`default_nettype wire

FILE: src/u8u16_queue.sv
`default_nettype none

module u8u16_queue
  import u8u16_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire unit_batch_t  push,
  output logic              room,
  output logic              unit_valid,
  input  wire logic         unit_stall,
  output unit_item_t        unit_data
);

  unit_item_t         mem [QueueDepth];
  logic [QueueAw-1:0] wr_ptr;
  logic [QueueAw-1:0] rd_ptr;
  logic [CntW-1:0]    count;
  logic               pop;

  assign room       = (count <= CntW'(QueueDepth - MaxUnits));
  assign unit_valid = (count != '0);
  assign unit_data  = mem[rd_ptr];
  assign pop        = unit_valid && !unit_stall;

  // Multi-entry write, single-entry read
  always_ff @(posedge clk) begin
    for (int i = 0; i < MaxUnits; i++) begin
      if (NumW'(i) < push.num) begin
        mem[wr_ptr + QueueAw'(i)] <= push.units[i];
      end
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QueueAw'(push.num);
      rd_ptr <= rd_ptr + QueueAw'(pop);
      count  <= count + CntW'(push.num) - CntW'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (push.num != '0) |-> (CntW'(push.num) + count) <= CntW'(QueueDepth))
    else $error("result queue overflow");

  a_count_track: assert property (@(posedge clk) disable iff (rst)
    (push.num == '0 && !pop) |=> $stable(count))
    else $error("fill count moved without push or pop");

endmodule

`default_nettype wire

FILE: src/utf8_to_utf16_stream_decoder.sv
`default_nettype none

// UTF-8 to UTF-16 stream decoder.
// Input channel (byte_valid / byte_stall / byte_data): one UTF-8 byte per
// item, with end_of_buffer marking the last byte of a buffer; any sequence
// still open after that byte is flushed as replacement units.
// Output channel (unit_valid / unit_stall / unit_data): one UTF-16 code unit
// per item; last_of_run marks the final unit caused by a byte and
// end_of_text the final unit of a byte that closed a buffer.
// Throughput: one byte per cycle while each byte yields at most one unit and
// the output is not stalled; a byte yielding several units holds the output
// longer, bounded by the single read port of the 8-entry result queue.
// The input register hands a byte to the decoder only when the queue has
// room for the four units one byte can produce; otherwise byte_stall rises.
// A stalled output keeps its unit; the queue absorbs further bytes until
// fewer than four entries are free. Reset (synchronous) empties the queue
// and clears the open sequence.
module utf8_to_utf16_stream_decoder
  import u8u16_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        byte_valid,
  output logic             byte_stall,
  input  wire byte_item_t  byte_data,
  output logic             unit_valid,
  input  wire logic        unit_stall,
  output unit_item_t       unit_data
);

  logic        iq_valid;
  byte_item_t  iq_item;
  logic        room;
  logic        advance;
  unit_batch_t dec_batch;
  unit_batch_t push;

  assign advance    = iq_valid && room;
  assign byte_stall = iq_valid && !room;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      iq_valid <= 1'b0;
    end else if (!byte_stall) begin
      iq_valid <= byte_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!byte_stall && byte_valid) begin
      iq_item <= byte_data;
    end
  end

  u8u16_dec u_dec (
    .clk   (clk),
    .rst   (rst),
    .fire  (advance),
    .item  (iq_item),
    .batch (dec_batch)
  );

  // Only a decoded byte writes the queue
  always_comb begin
    push = dec_batch;
    if (!advance) begin
      push.num = '0;
    end
  end

  u8u16_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .room       (room),
    .unit_valid (unit_valid),
    .unit_stall (unit_stall),
    .unit_data  (unit_data)
  );

endmodule

`default_nettype wire

FILE: tb/tb_utf8_to_utf16_stream_decoder.sv
`timescale 1ns / 1ps

module tb_utf8_to_utf16_stream_decoder;
  import u8u16_pkg::*;

  localparam int ByteCount   = 380;
  localparam int QuietLimit  = 1000;
  localparam int HoldOff     = 60;
  localparam int PredictOnly = -1;

  logic       clk;
  logic       rst;
  logic       byte_valid;
  logic       byte_stall;
  byte_item_t byte_data;
  logic       unit_valid;
  logic       unit_stall;
  unit_item_t unit_data;

  utf8_to_utf16_stream_decoder i_dut (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_data  (byte_data),
    .unit_valid (unit_valid),
    .unit_stall (unit_stall),
    .unit_data  (unit_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Decoder state mirror
  logic [2:0]  seq_len;
  logic [1:0]  cont_seen;
  logic [20:0] cp_acc;

  // Units caused by the current byte, then the queue of units still owed
  unit_item_t run_buf [4];
  int         run_len;
  unit_item_t units_due [$];

  int errors;
  int bytes_sent;
  int units_seen;
  int quiet_cycles;
  int tx_calm;
  int rx_calm;
  unit_item_t want;

  // Directed bytes; n is the typed unit count, or PredictOnly
  typedef struct {
    logic [7:0]  b;
    logic        eob;
    int          n;
    logic [15:0] cu;
    logic        rep;
  } script_row_t;

  script_row_t script [25] = '{
    // ASCII extremes
    '{8'h00, 1'b0, 1, 16'h0000, 1'b0},
    '{8'h7F, 1'b0, 1, 16'h007F, 1'b0},
    // invalid leads: stray continuation and 0xFF
    '{8'h80, 1'b0, 1, ReplChar, 1'b1},
    '{8'hFF, 1'b0, 1, ReplChar, 1'b1},
    // 2-, 3- and 4-byte characters
    '{8'hC2, 1'b0, PredictOnly, 16'h0000, 1'b0},
    '{8'hA9, 1'b0, PredictOnly, 16'h0000, 1'b0},
    '{8'hE2, 1'b0, PredictOnly, 16'h0000, 1'b0},
    '{8'h82, 1'b0, PredictOnly, 16'h0000, 1'b0},
    '{8'hAC, 1'b0, PredictOnly, 16'h0000, 1'b0},
    '{8'hF0, 1'b0, PredictOnly, 16'h0000, 1'b0},
    '{8'h9F, 1'b0, PredictOnly, 16'h0000, 1'b0},
    '{8'h98, 1'b0, PredictOnly, 16'h0000, 1'b0},
    '{8'h80, 1'b0, PredictOnly, 16'h0000, 1'b0},
    // 4-byte value above U+10FFFF
    '{8'hF4, 1'b0, 0, 16'h0000, 1'b0},
    '{8'h90, 1'b0, 0, 16'h0000, 1'b0},
    '{8'h80, 1'b0, 0, 16'h0000, 1'b0},
    '{8'h80, 1'b0, 1, ReplChar, 1'b1},
    // overlong NUL passes through
    '{8'hC0, 1'b0, PredictOnly, 16'h0000, 1'b0},
    '{8'h80, 1'b0, PredictOnly, 16'h0000, 1'b0},
    // sequence cut by a non-continuation byte
    '{8'hE3, 1'b0, PredictOnly, 16'h0000, 1'b0},
    '{8'h41, 1'b0, PredictOnly, 16'h0000, 1'b0},
    // buffer ends inside a sequence
    '{8'hF0, 1'b0, 0, 16'h0000, 1'b0},
    '{8'h90, 1'b0, 0, 16'h0000, 1'b0},
    '{8'h80, 1'b1, 3, ReplChar, 1'b1},
    // multi-byte lead with end of buffer
    '{8'hC3, 1'b1, 1, ReplChar, 1'b1}
  };

  task automatic add_unit(input logic [15:0] cu, input logic rep);
    if (run_len < MaxUnits) begin
      run_buf[run_len] = '{cu, rep, 1'b0, 1'b0};
      run_len++;
    end
  endtask

  task automatic clear_seq();
    seq_len   = LenNone;
    cont_seen = '0;
    cp_acc    = '0;
  endtask

  // One replacement for the lead plus one per collected continuation
  task automatic flush_seq();
    for (int k = 0; k < 1 + int'(cont_seen); k++) add_unit(ReplChar, 1'b1);
    clear_seq();
  endtask

  task automatic start_seq(input logic [7:0] b, input logic eob);
    if (!b[7]) begin
      add_unit({8'h00, b}, 1'b0);
    end else begin
      if ((b & Lead2Mask) == Lead2Tag) begin
        seq_len = Len2;
        cp_acc  = {13'd0, b & Pay2Mask};
      end else if ((b & Lead3Mask) == Lead3Tag) begin
        seq_len = Len3;
        cp_acc  = {13'd0, b & Pay3Mask};
      end else if ((b & Lead4Mask) == Lead4Tag) begin
        seq_len = Len4;
        cp_acc  = {13'd0, b & Pay4Mask};
      end else begin
        add_unit(ReplChar, 1'b1);
        return;
      end
      cont_seen = '0;
      if (eob) flush_seq();
    end
  endtask

  task automatic finish_seq();
    logic [20:0] off;
    if (seq_len == Len4) begin
      if (cp_acc >= SuppFirst && cp_acc <= SuppLast) begin
        off = cp_acc - SuppFirst;
        add_unit(HighSurrBase + {6'd0, off[19:10]}, 1'b0);
        add_unit(LowSurrBase + {6'd0, off[9:0]}, 1'b0);
      end else begin
        add_unit(ReplChar, 1'b1);
      end
    end else begin
      add_unit(cp_acc[15:0], 1'b0);
    end
    clear_seq();
  endtask

  // Fills run_buf with the units one byte causes
  task automatic decode_utf8_byte(input logic [7:0] b, input logic eob);
    run_len = 0;
    if (seq_len != LenNone) begin
      if ((b & ContMask) == ContTag) begin
        cp_acc    = {cp_acc[14:0], b[5:0]};
        cont_seen = cont_seen + 2'd1;
        if (int'(cont_seen) + 1 >= int'(seq_len)) finish_seq();
        else if (eob) flush_seq();
      end else begin
        flush_seq();
        start_seq(b, eob);
      end
    end else begin
      start_seq(b, eob);
    end
    if (run_len > 0) begin
      run_buf[run_len-1].last_of_run = 1'b1;
      run_buf[run_len-1].end_of_text = eob;
    end
  endtask

  // Mostly short gaps, a few long ones, and calm stretches with none
  function automatic int idle_len(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm = 40;
      return 0;
    end
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 25);
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic eob, input int typed_n,
                           input logic [15:0] typed_cu, input logic typed_rep);
    int gap;
    gap = idle_len(tx_calm);
    if (gap > 0) begin
      byte_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    byte_data  = '{data_byte: b, end_of_buffer: eob};
    byte_valid = 1'b1;
    @(posedge clk);
    while (byte_stall) @(posedge clk);
    bytes_sent++;
    decode_utf8_byte(b, eob);
    if (typed_n == PredictOnly) begin
      for (int k = 0; k < run_len; k++) units_due.push_back(run_buf[k]);
    end else begin
      for (int k = 0; k < typed_n; k++)
        units_due.push_back('{typed_cu, typed_rep, k == typed_n - 1,
                               (k == typed_n - 1) && eob});
    end
    @(negedge clk);
  endtask

  function automatic logic [7:0] cont_byte();
    return 8'h80 | 8'($urandom_range(0, 63));
  endfunction

  // One character or one piece of noise, mostly well formed
  task automatic send_random_char();
    logic [7:0] seq [4];
    int len;
    int kind;
    int cut;
    logic eob_end;
    kind    = $urandom_range(0, 99);
    eob_end = ($urandom_range(0, 9) == 0);
    len     = 1;
    if (kind < 20) begin
      seq[0] = 8'($urandom_range(0, 127));
    end else if (kind < 86) begin
      if (kind < 40) begin
        len    = 2;
        seq[0] = 8'hC0 | 8'($urandom_range(0, 31));
      end else if (kind < 60) begin
        len    = 3;
        seq[0] = 8'hE0 | 8'($urandom_range(0, 15));
      end else begin
        len    = 4;
        seq[0] = 8'hF0 | 8'($urandom_range(0, 7));
      end
      for (int k = 1; k < len; k++) seq[k] = cont_byte();
      // truncated sequence
      if (kind >= 78) len = $urandom_range(1, len - 1);
    end else if (kind < 94) begin
      seq[0] = 8'($urandom_range(0, 255));
    end else begin
      seq[0] = cont_byte();
    end
    // occasionally end the buffer mid-sequence
    cut = ($urandom_range(0, 19) == 0) ? $urandom_range(0, len - 1) : -1;
    for (int k = 0; k < len; k++)
      send_byte(seq[k], (k == cut) || (eob_end && k == len - 1), PredictOnly, '0, 1'b0);
  endtask

  task automatic compare_field(input string name, input logic [15:0] exp_v,
                               input logic [15:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %h, actual %h", name, exp_v, act_v);
      errors++;
    end
  endtask

  // Output check and watchdog
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if ((byte_valid && !byte_stall) || (unit_valid && !unit_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QuietLimit) begin
        $display("tb_utf8_to_utf16_stream_decoder NOT OK");
        $finish;
      end
      if (unit_valid && !unit_stall) begin
        units_seen++;
        if (units_due.size() == 0) begin
          $error("unexpected unit: code_unit %h", unit_data.code_unit);
          errors++;
        end else begin
          want = units_due.pop_front();
          compare_field("code_unit", want.code_unit, unit_data.code_unit);
          compare_field("is_replacement", 16'(want.is_replacement),
                        16'(unit_data.is_replacement));
          compare_field("last_of_run", 16'(want.last_of_run), 16'(unit_data.last_of_run));
          compare_field("end_of_text", 16'(want.end_of_text), 16'(unit_data.end_of_text));
        end
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off so the block backs up
  initial begin
    int n;
    bit held;
    unit_stall = 1'b0;
    held       = 1'b0;
    rx_calm    = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (!held && units_seen >= 100) begin
        held       = 1'b1;
        unit_stall = 1'b1;
        repeat (HoldOff) @(negedge clk);
        unit_stall = 1'b0;
      end else begin
        n = idle_len(rx_calm);
        if (n > 0) begin
          unit_stall = 1'b1;
          repeat (n) @(negedge clk);
          unit_stall = 1'b0;
        end
      end
      @(negedge clk);
    end
  end

  // Stimulus
  initial begin
    rst          = 1'b1;
    byte_valid   = 1'b0;
    byte_data    = '0;
    errors       = 0;
    bytes_sent   = 0;
    units_seen   = 0;
    tx_calm      = 0;
    run_len      = 0;
    clear_seq();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (script[i])
      send_byte(script[i].b, script[i].eob, script[i].n, script[i].cu, script[i].rep);
    while (bytes_sent < ByteCount) send_random_char();
    byte_valid = 1'b0;

    while (units_due.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    if (errors == 0) begin
      $display("tb_utf8_to_utf16_stream_decoder OK");
    end else begin
      $display("tb_utf8_to_utf16_stream_decoder NOT OK");
    end
    $finish;
  end

endmodule
